// ===== src/s98enc_pkg.sv =====
// Package for the S98 command stream encoder: constants, operation codes,
// controller state type and the control/status structs of the wait unit.
// No dependencies.
`default_nettype none
package s98enc_pkg;

   localparam int MAX_SLOTS = 32;
   localparam int SLOT_W    = 5;
   localparam int ADDR_W    = 9;
   localparam int BYTE_W    = 8;
   localparam int PEND_W    = 32;
   localparam int DIGIT_W   = 8;                 // adder digit per cycle
   localparam int STEPS     = PEND_W / DIGIT_W;  // digits per serial add
   localparam int CNT_W     = $clog2(STEPS);
   localparam int VAR_W     = 7;                 // varint payload bits per byte
   localparam int CMP_W     = 7;                 // covers MAX_SLOTS range

   localparam logic [BYTE_W-1:0] WAIT_ONE_CODE  = 8'hFF;
   localparam logic [BYTE_W-1:0] WAIT_LONG_CODE = 8'hFE;
   localparam logic [BYTE_W-1:0] END_CODE       = 8'hFD;
   localparam logic [PEND_W-1:0] MINUS_TWO      = 32'hFFFF_FFFE;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_WAIT  = 2'd1,
      OP_FLUSH = 2'd2,
      OP_END   = 2'd3
   } s98enc_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADD,
      ST_SUB,
      ST_ONE,
      ST_FE,
      ST_VAR,
      ST_CMD,
      ST_ADR,
      ST_VAL,
      ST_FD
   } s98enc_state_type;

   typedef struct packed {
      logic              load;
      logic              saturate;
      logic [PEND_W-1:0] operand;
      logic              shift;
      logic              clear;
   } s98enc_wctl_type;

   typedef struct packed {
      logic             busy;
      logic             zero;
      logic             one;
      logic             more;
      logic [VAR_W-1:0] digit;
   } s98enc_wstat_type;

   // state that follows once the pending wait has been written out
   function automatic s98enc_state_type tail_state(input s98enc_op_type op);
      s98enc_state_type st;
      unique case (op)
         OP_WRITE: st = ST_CMD;
         OP_END:   st = ST_FD;
         default:  st = ST_IDLE;
      endcase
      return st;
   endfunction

endpackage
`default_nettype wire

// ===== src/s98enc_wait.sv =====
// Pending wait register with a byte-serial adder (saturating add of ticks,
// or subtract of two) and a 7-bit digit shifter for varint output.
// Depends on s98enc_pkg.
`default_nettype none
module s98enc_wait (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire s98enc_pkg::s98enc_wctl_type  ctl,
   output      s98enc_pkg::s98enc_wstat_type stat
);

   logic [s98enc_pkg::PEND_W-1:0]  pend_ff, pend_in;
   logic [s98enc_pkg::PEND_W-1:0]  opnd_ff, opnd_in;
   logic                           carry_ff, carry_in;
   logic [s98enc_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           sat_ff, sat_in;
   logic [s98enc_pkg::DIGIT_W:0]   sum;

   always_comb begin
      sum = {1'b0, pend_ff[s98enc_pkg::DIGIT_W-1:0]}
          + {1'b0, opnd_ff[s98enc_pkg::DIGIT_W-1:0]}
          + {{s98enc_pkg::DIGIT_W{1'b0}}, carry_ff};
      pend_in  = pend_ff;
      opnd_in  = opnd_ff;
      carry_in = carry_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      sat_in   = sat_ff;
      priority if (ctl.load) begin
         opnd_in  = ctl.operand;
         sat_in   = ctl.saturate;
         carry_in = 1'b0;
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         // rotate: new sum digit enters at the top
         pend_in  = {sum[s98enc_pkg::DIGIT_W-1:0],
                     pend_ff[s98enc_pkg::PEND_W-1:s98enc_pkg::DIGIT_W]};
         opnd_in  = opnd_ff >> s98enc_pkg::DIGIT_W;
         carry_in = sum[s98enc_pkg::DIGIT_W];
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == s98enc_pkg::CNT_W'(s98enc_pkg::STEPS - 1)) begin
            busy_in = 1'b0;
            if (sat_ff && sum[s98enc_pkg::DIGIT_W]) begin
               pend_in = '1;
            end
         end
      end else if (ctl.shift) begin
         pend_in = pend_ff >> s98enc_pkg::VAR_W;
      end else if (ctl.clear) begin
         pend_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         busy_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
         busy_ff <= busy_in;
      end
      opnd_ff  <= opnd_in;
      carry_ff <= carry_in;
      cnt_ff   <= cnt_in;
      sat_ff   <= sat_in;
   end

   assign stat.busy  = busy_ff;
   assign stat.zero  = (pend_ff == '0);
   assign stat.one   = (pend_ff == s98enc_pkg::PEND_W'(1));
   assign stat.more  = |pend_ff[s98enc_pkg::PEND_W-1:s98enc_pkg::VAR_W];
   assign stat.digit = pend_ff[s98enc_pkg::VAR_W-1:0];

endmodule
`default_nettype wire

// ===== src/s98enc_obuf.sv =====
// Output register for the response channel: holds one byte transfer and
// lets the controller push the next one in the cycle the current one leaves.
// Depends on s98enc_pkg.
`default_nettype none
module s98enc_obuf (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          push,
   input  wire logic [s98enc_pkg::BYTE_W-1:0] push_byte,
   input  wire logic                          push_last,
   output      logic                          free,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output      logic [s98enc_pkg::BYTE_W-1:0] rsp_out_byte,
   output      logic                          rsp_last
);

   logic                          valid_ff, valid_in;
   logic [s98enc_pkg::BYTE_W-1:0] byte_ff, byte_in;
   logic                          last_ff, last_in;

   always_comb begin
      free     = !valid_ff || rsp_ready;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      priority if (push) begin
         valid_in = 1'b1;
         byte_in  = push_byte;
         last_in  = push_last;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_last     = last_ff;

endmodule
`default_nettype wire

// ===== src/s98_register_log_encoder_unit.sv =====
// Top level of the S98 command stream encoder: request capture, sequencer,
// wait unit and response register.
// Depends on s98enc_pkg, s98enc_wait, s98enc_obuf.
// Wait item: accept, byte-serial add in ST_ADD, then back to ST_IDLE.
// Flush of a wait > 1: serial subtract in ST_SUB, then 0xFE, then one byte per cycle
// unless the output stalls (1 to 5 varint bytes); write adds 3 bytes, end 1.
// One item at a time; with no wait pending, the first byte goes from its sequencer
// state into the response register. Reset clears pending wait, busy, state, valid.
`default_nettype none
module s98_register_log_encoder_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_ready,
   input  wire logic [1:0]                    req_operation,
   input  wire logic [s98enc_pkg::SLOT_W-1:0] req_device_slot,
   input  wire logic [s98enc_pkg::ADDR_W-1:0] req_reg_addr,
   input  wire logic [s98enc_pkg::BYTE_W-1:0] req_reg_value,
   input  wire logic [s98enc_pkg::PEND_W-1:0] req_ticks,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output      logic [s98enc_pkg::BYTE_W-1:0] rsp_out_byte,
   output      logic                          rsp_last
);

   s98enc_pkg::s98enc_state_type  state_ff, state_in;
   s98enc_pkg::s98enc_op_type     op_ff, op_in, req_op;
   logic [s98enc_pkg::SLOT_W-1:0] slot_ff, slot_in;
   logic [s98enc_pkg::ADDR_W-1:0] addr_ff, addr_in;
   logic [s98enc_pkg::BYTE_W-1:0] value_ff, value_in;

   s98enc_pkg::s98enc_wctl_type   wctl;
   s98enc_pkg::s98enc_wstat_type  wstat;

   logic                          push, push_last, out_free, accept, slot_ok;
   logic [s98enc_pkg::BYTE_W-1:0] push_byte;

   assign req_op  = s98enc_pkg::s98enc_op_type'(req_operation);
   assign accept  = req_valid && req_ready;
   assign slot_ok = s98enc_pkg::CMP_W'(req_device_slot)
                    < s98enc_pkg::CMP_W'(s98enc_pkg::MAX_SLOTS);

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      slot_in   = slot_ff;
      addr_in   = addr_ff;
      value_in  = value_ff;
      req_ready = 1'b0;
      push      = 1'b0;
      push_last = 1'b0;
      push_byte = '0;
      wctl      = '0;
      unique case (state_ff)
         s98enc_pkg::ST_IDLE: begin
            req_ready = !wstat.busy;
            if (accept) begin
               op_in    = req_op;
               slot_in  = req_device_slot;
               addr_in  = req_reg_addr;
               value_in = req_reg_value;
               priority if (req_op == s98enc_pkg::OP_WAIT) begin
                  wctl.load     = 1'b1;
                  wctl.saturate = 1'b1;
                  wctl.operand  = req_ticks;
                  state_in      = s98enc_pkg::ST_ADD;
               end else if (req_op == s98enc_pkg::OP_WRITE && !slot_ok) begin
                  state_in = s98enc_pkg::ST_IDLE;
               end else if (wstat.one) begin
                  state_in = s98enc_pkg::ST_ONE;
               end else if (!wstat.zero) begin
                  wctl.load    = 1'b1;
                  wctl.operand = s98enc_pkg::MINUS_TWO;
                  state_in     = s98enc_pkg::ST_SUB;
               end else begin
                  state_in = s98enc_pkg::tail_state(req_op);
               end
            end
         end
         s98enc_pkg::ST_ADD: begin
            if (!wstat.busy) state_in = s98enc_pkg::ST_IDLE;
         end
         s98enc_pkg::ST_SUB: begin
            if (!wstat.busy) state_in = s98enc_pkg::ST_FE;
         end
         s98enc_pkg::ST_ONE: begin
            if (out_free) begin
               push       = 1'b1;
               push_byte  = s98enc_pkg::WAIT_ONE_CODE;
               push_last  = (op_ff == s98enc_pkg::OP_FLUSH);
               wctl.clear = 1'b1;
               state_in   = s98enc_pkg::tail_state(op_ff);
            end
         end
         s98enc_pkg::ST_FE: begin
            if (out_free) begin
               push      = 1'b1;
               push_byte = s98enc_pkg::WAIT_LONG_CODE;
               state_in  = s98enc_pkg::ST_VAR;
            end
         end
         s98enc_pkg::ST_VAR: begin
            if (out_free) begin
               push       = 1'b1;
               push_byte  = {wstat.more, wstat.digit};
               push_last  = !wstat.more && (op_ff == s98enc_pkg::OP_FLUSH);
               wctl.shift = 1'b1;
               if (!wstat.more) state_in = s98enc_pkg::tail_state(op_ff);
            end
         end
         s98enc_pkg::ST_CMD: begin
            if (out_free) begin
               push      = 1'b1;
               push_byte = s98enc_pkg::BYTE_W'({slot_ff, addr_ff[s98enc_pkg::ADDR_W-1]});
               state_in  = s98enc_pkg::ST_ADR;
            end
         end
         s98enc_pkg::ST_ADR: begin
            if (out_free) begin
               push      = 1'b1;
               push_byte = addr_ff[s98enc_pkg::BYTE_W-1:0];
               state_in  = s98enc_pkg::ST_VAL;
            end
         end
         s98enc_pkg::ST_VAL: begin
            if (out_free) begin
               push      = 1'b1;
               push_byte = value_ff;
               push_last = 1'b1;
               state_in  = s98enc_pkg::ST_IDLE;
            end
         end
         s98enc_pkg::ST_FD: begin
            if (out_free) begin
               push      = 1'b1;
               push_byte = s98enc_pkg::END_CODE;
               push_last = 1'b1;
               state_in  = s98enc_pkg::ST_IDLE;
            end
         end
         default: state_in = s98enc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= s98enc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff    <= op_in;
      slot_ff  <= slot_in;
      addr_ff  <= addr_in;
      value_ff <= value_in;
   end

   s98enc_wait u_wait (
      .clock (clock),
      .reset (reset),
      .ctl   (wctl),
      .stat  (wstat)
   );

   s98enc_obuf u_obuf (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .push_byte    (push_byte),
      .push_last    (push_last),
      .free         (out_free),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

   // the serial adder runs only while the sequencer waits on it
   a_busy_state: assert property (@(posedge clock) disable iff (reset)
      wstat.busy |-> (state_ff == s98enc_pkg::ST_ADD || state_ff == s98enc_pkg::ST_SUB))
      else $error("wait unit busy outside add/sub");

   // a wait item never produces a byte
   a_add_silent: assert property (@(posedge clock) disable iff (reset)
      (state_ff == s98enc_pkg::ST_ADD) |-> !push)
      else $error("byte pushed during wait accumulation");

   // 0xFE only follows a finished subtract
   a_fe_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == s98enc_pkg::ST_FE) |->
         ($past(state_ff) == s98enc_pkg::ST_SUB || $past(state_ff) == s98enc_pkg::ST_FE))
      else $error("long wait code without subtract");

   // no new item while the wait unit is still working
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (state_ff == s98enc_pkg::ST_IDLE && !wstat.busy))
      else $error("request ready while busy");

endmodule
`default_nettype wire

// ===== tb/tb_s98_register_log_encoder_unit.sv =====
// Self-checking testbench for the S98 command stream encoder: directed table, then
// random register logs in four idle/stall phases; bytes checked vs typed-in or predicted values.
// Depends on s98enc_pkg and s98_register_log_encoder_unit.
`default_nettype none
module tb_s98_register_log_encoder_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import s98enc_pkg::*;

   typedef struct packed {
      s98enc_op_type     op;
      logic [SLOT_W-1:0] slot;
      logic [ADDR_W-1:0] addr;
      logic [BYTE_W-1:0] value;
      logic [PEND_W-1:0] ticks;
      logic              has_fixed;   // bytes below are typed in, not predicted
      logic [3:0]        n_fixed;
      logic [63:0]       fixed_bytes; // right-aligned, last byte in bits 7:0
   } log_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [1:0]        req_operation = OP_WRITE;
   logic [SLOT_W-1:0] req_device_slot = '0;
   logic [ADDR_W-1:0] req_reg_addr = '0;
   logic [BYTE_W-1:0] req_reg_value = '0;
   logic [PEND_W-1:0] req_ticks = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [BYTE_W-1:0] rsp_out_byte;
   logic              rsp_last;

   s98_register_log_encoder_unit uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_device_slot (req_device_slot),
      .req_reg_addr    (req_reg_addr),
      .req_reg_value   (req_reg_value),
      .req_ticks       (req_ticks),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last        (rsp_last)
   );

   log_row_type       directed[$];
   logic [8:0]        stream_q[$];   // {byte, last} still to come from the block
   logic [PEND_W-1:0] pend_ticks = '0;
   logic [8:0]        oldest;
   int                idle_pct = 0;
   int                stall_pct = 0;
   int                n_errors = 0;
   int                n_bytes = 0;
   int                n_items = 0;
   int                n_nine = 0;
   int                n_by_op[4] = '{0, 0, 0, 0};

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("timeout: %0d results still pending", stream_q.size());
      $display("[s98_register_log_encoder_unit] ERROR");
      $finish;
   end

   // Byte stream that one log item produces; updates the pending wait.
   function automatic int encode_item(input log_row_type r, inout logic [PEND_W-1:0] pend,
                                      output logic [8:0][7:0] b);
      int                n;
      logic [PEND_W-1:0] rest;
      logic [PEND_W:0]   sum;
      n = 0;
      b = '0;
      if (r.op == OP_WAIT) begin
         sum = {1'b0, pend} + {1'b0, r.ticks};
         pend = sum[PEND_W] ? '1 : sum[PEND_W-1:0];
         return 0;
      end
      if (r.op == OP_WRITE && int'(r.slot) >= MAX_SLOTS) return 0;
      if (pend == 1) begin
         b[n] = WAIT_ONE_CODE;
         n++;
      end else if (pend > 1) begin
         rest = pend - 2;
         b[n] = WAIT_LONG_CODE;
         n++;
         do begin
            b[n] = {(rest > 127), rest[6:0]};
            rest = rest >> 7;
            n++;
         end while (rest != 0);
      end
      pend = '0;
      if (r.op == OP_WRITE) begin
         b[n] = {2'b00, r.slot, r.addr[8]};
         b[n + 1] = r.addr[7:0];
         b[n + 2] = r.value;
         n += 3;
      end else if (r.op == OP_END) begin
         b[n] = END_CODE;
         n++;
      end
      return n;
   endfunction

   task automatic add_row(input s98enc_op_type op, input int slot, input int addr,
                          input int value, input logic [31:0] ticks, input int fixed,
                          input int n, input logic [63:0] bytes);
      log_row_type r;
      r.op = op;
      r.slot = slot[SLOT_W-1:0];
      r.addr = addr[ADDR_W-1:0];
      r.value = value[BYTE_W-1:0];
      r.ticks = ticks;
      r.has_fixed = (fixed != 0);
      r.n_fixed = n[3:0];
      r.fixed_bytes = bytes;
      directed.insert(directed.size(), r);
   endtask

   task automatic build_directed();
      add_row(OP_END,   0, 0, 0, 0, 1, 1, 'hFD);
      add_row(OP_FLUSH, 0, 0, 0, 0, 1, 0, 0);                 // empty flush
      add_row(OP_WRITE, 0, 0, 0, 0, 1, 3, 'h000000);
      add_row(OP_WRITE, 31, 'h1FF, 'hFF, '1, 1, 3, 'h3FFFFF);
      add_row(OP_WAIT,  31, 'h1FF, 'hFF, 1, 1, 0, 0);
      add_row(OP_FLUSH, 0, 0, 0, 0, 1, 1, 'hFF);              // one-tick wait
      add_row(OP_WAIT,  0, 0, 0, 2, 1, 0, 0);
      add_row(OP_WRITE, 1, 'h100, 'h5A, 0, 1, 5, 64'hFE0003005A);
      add_row(OP_WAIT,  0, 0, 0, '1, 1, 0, 0);
      add_row(OP_WAIT,  0, 0, 0, 5, 1, 0, 0);                 // saturates
      add_row(OP_END,   0, 0, 0, 0, 1, 7, 64'hFEFDFFFFFF0FFD);
      add_row(OP_WAIT,  0, 0, 0, 0, 1, 0, 0);
      add_row(OP_FLUSH, 0, 0, 0, 0, 1, 0, 0);
      add_row(OP_WAIT,  0, 0, 0, 129, 0, 0, 0);
      add_row(OP_FLUSH, 0, 0, 0, 0, 0, 0, 0);
      add_row(OP_WAIT,  0, 0, 0, 130, 0, 0, 0);
      add_row(OP_WRITE, 16, 'h0AA, 'h55, 0, 0, 0, 0);
      add_row(OP_WAIT,  0, 0, 0, '1, 0, 0, 0);
      add_row(OP_WRITE, 7, 'h1C3, 'h81, 0, 0, 0, 0);          // nine bytes
      add_row(OP_WAIT,  0, 0, 0, 'h8000_0000, 0, 0, 0);
      add_row(OP_WAIT,  0, 0, 0, 'h8000_0000, 0, 0, 0);
      add_row(OP_END,   0, 0, 0, 0, 0, 0, 0);
      add_row(OP_WAIT,  0, 0, 0, 3, 0, 0, 0);
      add_row(OP_WAIT,  0, 0, 0, 'h3FFF, 0, 0, 0);
      add_row(OP_FLUSH, 0, 0, 0, 0, 0, 0, 0);
   endtask

   function automatic log_row_type random_row();
      log_row_type r;
      int          sel;
      sel = $urandom_range(99);
      if (sel < 40) r.op = OP_WRITE;
      else if (sel < 72) r.op = OP_WAIT;
      else if (sel < 85) r.op = OP_FLUSH;
      else r.op = OP_END;
      r.slot = SLOT_W'($urandom);
      r.addr = ADDR_W'($urandom);
      r.value = BYTE_W'($urandom);
      case ($urandom_range(9))
         0, 1, 2, 3: r.ticks = $urandom_range(3);
         4, 5, 6:    r.ticks = $urandom_range(20000);
         7:          r.ticks = $urandom;
         8:          r.ticks = 32'hFFFF_FFFF - $urandom_range(3);
         default:    r.ticks = (32'd1 << $urandom_range(31)) + $urandom_range(2);
      endcase
      r.has_fixed = 1'b0;
      r.n_fixed = '0;
      r.fixed_bytes = '0;
      return r;
   endfunction

   task automatic send_item(input log_row_type r);
      logic [8:0][7:0] b;
      int              n;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= r.op;
      req_device_slot <= r.slot;
      req_reg_addr <= r.addr;
      req_reg_value <= r.value;
      req_ticks <= r.ticks;
      do @(posedge clock); while (req_ready !== 1'b1);
      // transfer taken at this edge
      n_items++;
      n_by_op[r.op]++;
      n = encode_item(r, pend_ticks, b);
      if (n == 9) n_nine++;
      if (r.has_fixed) n = int'(r.n_fixed);
      for (int k = 0; k < n; k++) begin
         stream_q.insert(stream_q.size(),
                         {r.has_fixed ? r.fixed_bytes[8 * (n - 1 - k) +: 8] : b[k],
                          k == n - 1});
      end
   endtask

   // sender holds off until every expected byte is out
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (stream_q.size() != 0);
   endtask

   task automatic flag_error(input string what, input logic [7:0] want, input logic [7:0] got);
      n_errors++;
      if (n_errors <= 10)
         $display("mismatch at %0t: %s expected %02h got %02h", $realtime, what, want, got);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         n_bytes++;
         if (stream_q.size() == 0) begin
            flag_error("byte with nothing pending", 8'h00, rsp_out_byte);
         end else begin
            oldest = stream_q.pop_front();
            if (rsp_out_byte !== oldest[8:1]) flag_error("out_byte", oldest[8:1], rsp_out_byte);
            if (rsp_last !== oldest[0]) flag_error("last", {7'd0, oldest[0]}, {7'd0, rsp_last});
         end
      end
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      build_directed();
      foreach (directed[i]) send_item(directed[i]);
      drain_results();
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 67; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 67; end
            default: begin idle_pct = 18; stall_pct = 18; end
         endcase
         repeat (88) send_item(random_row());
         drain_results();
      end
      repeat (32) @(posedge clock);
      if (stream_q.size() != 0) n_errors++;
      $display("%0d log items: %0d writes, %0d waits, %0d flushes, %0d ends",
               n_items, n_by_op[OP_WRITE], n_by_op[OP_WAIT], n_by_op[OP_FLUSH], n_by_op[OP_END]);
      $display("%0d stream bytes checked, %0d nine-byte writes, %0d mismatches",
               n_bytes, n_nine, n_errors);
      if (n_errors == 0) begin
         $display("[s98_register_log_encoder_unit] OK");
      end else begin
         $display("[s98_register_log_encoder_unit] ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire
